@@ rtl/spbpm_pkg.sv @@
// ----------------------------------------------------------------------------
// spbpm_pkg
// Types and constants shared by the spectrum bar peak meter modules.
// ----------------------------------------------------------------------------
package spbpm_pkg;

    // configuration port
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 16;

    localparam logic [CFG_IW-1:0] REG_FREEZE = 3'd0;
    localparam logic [CFG_IW-1:0] REG_STOP_0 = 3'd1;
    localparam logic [CFG_IW-1:0] REG_STOP_1 = 3'd2;
    localparam logic [CFG_IW-1:0] REG_STOP_2 = 3'd3;
    localparam logic [CFG_IW-1:0] REG_STOP_3 = 3'd4;

    localparam logic [15:0] RESET_STOP_0 = 16'h3732;
    localparam logic [15:0] RESET_STOP_1 = 16'h071F;
    localparam logic [15:0] RESET_STOP_2 = 16'hB2DF;
    localparam logic [15:0] RESET_STOP_3 = 16'hF9F6;

    // request kinds
    localparam logic OP_BIN   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    localparam logic [7:0] FULL_HEIGHT = 8'd200;
    localparam logic [7:0] SEG1_TOP    = 8'd66;
    localparam logic [7:0] SEG2_TOP    = 8'd133;
    localparam logic [7:0] FULL_SCALE  = 8'd255;

    // reciprocal multipliers: floor(x / N) == (x * MUL) >> SHIFT over the used range
    localparam logic [16:0] MUL_DIV255_H = 17'd65794;   // x < 2**16
    localparam int          SHIFT_H      = 24;
    localparam logic [16:0] MUL_DIV66    = 17'd127101;  // x < 2**15
    localparam logic [16:0] MUL_DIV67    = 17'd125204;
    localparam int          SHIFT_T      = 23;
    localparam logic [14:0] MUL_DIV255_C = 15'd16449;   // x < 2**14
    localparam int          SHIFT_C      = 22;

    typedef enum logic [1:0] {
        SEG_LOW,
        SEG_MID,
        SEG_HIGH
    } seg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_SCALE,
        ST_HGT,
        ST_PEAK,
        ST_TSEG,
        ST_MIX,
        ST_DIV
    } state_t;

    typedef struct packed {
        logic clear;
        logic bin_acc;
        logic bin_last;
        logic avg_en;
        logic scale_en;
        logic hgt_en;
        logic peak_en;
        logic tseg_en;
        logic mix_en;
        logic div_en;
    } cmd_t;

    typedef struct packed {
        logic opcode;
        logic freeze;
        logic last_bin;
        logic out_busy;
    } status_t;

endpackage

@@ rtl/spbpm_ram.sv @@
// ----------------------------------------------------------------------------
// spbpm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spbpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/spbpm_ctrl.sv @@
// ----------------------------------------------------------------------------
// spbpm_ctrl
// Sequencer: takes bins, then a bar step per cycle; the last waits for output.
// ----------------------------------------------------------------------------
module spbpm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  spbpm_pkg::status_t status,
    output spbpm_pkg::cmd_t    cmd
);

    import spbpm_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && status.opcode == OP_BIN && !status.freeze
                        && status.last_bin) begin
                    state_next = ST_AVG;
                end
            end
            ST_AVG:   state_next = ST_SCALE;
            ST_SCALE: state_next = ST_HGT;
            ST_HGT:   state_next = ST_PEAK;
            ST_PEAK:  state_next = ST_TSEG;
            ST_TSEG:  state_next = ST_MIX;
            ST_MIX:   state_next = ST_DIV;
            ST_DIV: begin
                // hold until the output register is free
                if (!status.out_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    priority if (status.opcode == OP_CLEAR) begin
                        cmd.clear = 1'b1;
                    end else if (status.freeze) begin
                        // drop the bin
                    end else if (status.last_bin) begin
                        cmd.bin_last = 1'b1;
                    end else begin
                        cmd.bin_acc = 1'b1;
                    end
                end
            end
            ST_AVG:   cmd.avg_en   = 1'b1;
            ST_SCALE: cmd.scale_en = 1'b1;
            ST_HGT:   cmd.hgt_en   = 1'b1;
            ST_PEAK:  cmd.peak_en  = 1'b1;
            ST_TSEG:  cmd.tseg_en  = 1'b1;
            ST_MIX:   cmd.mix_en   = 1'b1;
            ST_DIV:   cmd.div_en   = !status.out_busy;
            default:  cmd = '0;
        endcase
    end

endmodule

@@ rtl/spbpm_datapath.sv @@
// ----------------------------------------------------------------------------
// spbpm_datapath
// Bin accumulator, height scaling, peak store and gradient colour math.
// ----------------------------------------------------------------------------
module spbpm_datapath #(
    parameter int BARS     = 16,
    parameter int BAR_BINS = 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  spbpm_pkg::cmd_t                cmd,
    output spbpm_pkg::status_t             status,
    input  logic                           cfg_wr_en,
    input  logic [spbpm_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [spbpm_pkg::CFG_DW-1:0]   cfg_wdata,
    input  logic                           in_opcode,
    input  logic [7:0]                     in_bin_value,
    input  logic                           m_tready,
    output logic                           m_tvalid,
    output logic [3:0]                     out_bar_index,
    output logic [7:0]                     out_bar_height,
    output logic [7:0]                     out_peak_height,
    output logic [15:0]                    out_bar_color,
    output logic                           out_last_bar
);

    import spbpm_pkg::*;

    localparam int PW        = (BAR_BINS > 1) ? $clog2(BAR_BINS) : 1;
    localparam int SW        = 8 + $clog2(BAR_BINS);
    localparam int BW        = (BARS > 1) ? $clog2(BARS) : 1;
    localparam int AVG_SHIFT = SW + $clog2(BAR_BINS);
    localparam int AVG_MW    = AVG_SHIFT + 1;
    localparam int AVG_PW    = SW + AVG_MW;
    localparam logic [AVG_MW-1:0] AVG_MUL =
        AVG_MW'((2**AVG_SHIFT + BAR_BINS - 1) / BAR_BINS);

    // configuration
    logic        freeze_reg;
    logic [15:0] stop_reg [4];

    // accumulation and bar tracking
    logic [SW-1:0] sum_reg;
    logic [SW-1:0] sum_full_reg;
    logic [PW-1:0] pos_reg;
    logic [BW-1:0] bar_pos_reg;
    logic [BW-1:0] bar_cur_reg;
    logic [BARS-1:0] valid_reg;
    logic [SW-1:0] sum_next;

    // per-bar math
    logic [7:0]  avg_reg;
    logic [15:0] hx_reg;
    logic [7:0]  h_reg;
    logic [7:0]  peak_reg;
    seg_t        seg_reg;
    logic [14:0] tx_reg;
    logic [7:0]  t_reg;
    logic [15:0] ca_reg;
    logic [15:0] cb_reg;
    logic [5:0]  ch_a_reg   [3];
    logic [13:0] ch_mag_reg [3];
    logic        ch_neg_reg [3];

    // output register
    logic        out_valid_reg;
    logic [3:0]  out_bar_reg;
    logic [7:0]  out_height_reg;
    logic [7:0]  out_peak_reg;
    logic [15:0] out_color_reg;
    logic        out_last_reg;

    logic [AVG_PW-1:0] avg_prod;
    logic [32:0]       h_prod;
    logic [31:0]       t_prod;
    logic [7:0]        h_base;
    seg_t              seg_sel;
    logic [7:0]        h_off;
    logic [7:0]        stored_peak;
    logic [7:0]        peak_new;
    logic [7:0]        rd_peak;
    logic [5:0]        ca_ch [3];
    logic [5:0]        cb_ch [3];
    logic [5:0]        d_mag [3];
    logic              d_neg [3];
    logic [13:0]       m_mag [3];
    logic [28:0]       q_prod [3];
    logic [5:0]        ch_res [3];
    logic [BW+3:0]     bar_ext;

    assign sum_next = sum_reg + SW'(in_bin_value);

    assign status.opcode   = in_opcode;
    assign status.freeze   = freeze_reg;
    assign status.last_bin = (pos_reg == PW'(BAR_BINS - 1));
    assign status.out_busy = out_valid_reg && !m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freeze_reg  <= 1'b0;
            stop_reg[0] <= RESET_STOP_0;
            stop_reg[1] <= RESET_STOP_1;
            stop_reg[2] <= RESET_STOP_2;
            stop_reg[3] <= RESET_STOP_3;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FREEZE: freeze_reg  <= cfg_wdata[0];
                REG_STOP_0: stop_reg[0] <= cfg_wdata;
                REG_STOP_1: stop_reg[1] <= cfg_wdata;
                REG_STOP_2: stop_reg[2] <= cfg_wdata;
                REG_STOP_3: stop_reg[3] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg     <= '0;
            pos_reg     <= '0;
            bar_pos_reg <= '0;
            valid_reg   <= '0;
        end else begin
            priority if (cmd.clear) begin
                sum_reg     <= '0;
                pos_reg     <= '0;
                bar_pos_reg <= '0;
                valid_reg   <= '0;
            end else if (cmd.bin_acc) begin
                sum_reg <= sum_next;
                pos_reg <= pos_reg + PW'(1);
            end else if (cmd.bin_last) begin
                sum_reg <= '0;
                pos_reg <= '0;
                if (bar_pos_reg == BW'(BARS - 1)) begin
                    bar_pos_reg <= '0;
                end else begin
                    bar_pos_reg <= bar_pos_reg + BW'(1);
                end
            end else if (cmd.peak_en) begin
                valid_reg[bar_cur_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.bin_last) begin
            sum_full_reg <= sum_next;
            bar_cur_reg  <= bar_pos_reg;
        end
    end

    // average and height
    assign avg_prod = AVG_PW'(sum_full_reg) * AVG_PW'(AVG_MUL);
    assign h_prod   = 33'(hx_reg) * 33'(MUL_DIV255_H);

    always_ff @(posedge aclk) begin
        if (cmd.avg_en) begin
            avg_reg <= avg_prod[AVG_SHIFT +: 8];
        end
        if (cmd.scale_en) begin
            hx_reg <= 16'(avg_reg) * 16'(FULL_HEIGHT);
        end
        if (cmd.hgt_en) begin
            h_reg <= h_prod[SHIFT_H +: 8];
        end
    end

    // peak update and gradient segment
    assign stored_peak = valid_reg[bar_cur_reg] ? rd_peak : 8'd0;
    assign peak_new    = (h_reg > stored_peak) ? h_reg : stored_peak;

    always_comb begin
        priority if (h_reg <= SEG1_TOP) begin
            seg_sel = SEG_LOW;
            h_base  = 8'd0;
        end else if (h_reg <= SEG2_TOP) begin
            seg_sel = SEG_MID;
            h_base  = SEG1_TOP;
        end else begin
            seg_sel = SEG_HIGH;
            h_base  = SEG2_TOP;
        end
    end

    assign h_off = h_reg - h_base;

    spbpm_ram #(
        .WIDTH (8),
        .DEPTH (BARS)
    ) u_peak_ram (
        .clk     (aclk),
        .wr_en   (cmd.peak_en),
        .wr_addr (bar_cur_reg),
        .wr_data (peak_new - 8'((peak_new != 8'd0) ? 1 : 0)),
        .rd_en   (cmd.avg_en),
        .rd_addr (bar_cur_reg),
        .rd_data (rd_peak)
    );

    assign t_prod = 32'(tx_reg) * 32'((seg_reg == SEG_LOW) ? MUL_DIV66 : MUL_DIV67);

    always_ff @(posedge aclk) begin
        if (cmd.peak_en) begin
            peak_reg <= peak_new;
            seg_reg  <= seg_sel;
            tx_reg   <= 15'(h_off) * 15'(FULL_SCALE);
        end
        if (cmd.tseg_en) begin
            t_reg <= t_prod[SHIFT_T +: 8];
            unique case (seg_reg)
                SEG_LOW: begin
                    ca_reg <= stop_reg[0];
                    cb_reg <= stop_reg[1];
                end
                SEG_MID: begin
                    ca_reg <= stop_reg[1];
                    cb_reg <= stop_reg[2];
                end
                default: begin
                    ca_reg <= stop_reg[2];
                    cb_reg <= stop_reg[3];
                end
            endcase
        end
    end

    // channel order: red, green, blue
    assign ca_ch[0] = {1'b0, ca_reg[15:11]};
    assign ca_ch[1] = ca_reg[10:5];
    assign ca_ch[2] = {1'b0, ca_reg[4:0]};
    assign cb_ch[0] = {1'b0, cb_reg[15:11]};
    assign cb_ch[1] = cb_reg[10:5];
    assign cb_ch[2] = {1'b0, cb_reg[4:0]};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d_neg[i]  = cb_ch[i] < ca_ch[i];
            d_mag[i]  = d_neg[i] ? (ca_ch[i] - cb_ch[i]) : (cb_ch[i] - ca_ch[i]);
            m_mag[i]  = 14'(d_mag[i]) * 14'(t_reg);
            // divide the magnitude so the quotient truncates toward zero
            q_prod[i] = 29'(ch_mag_reg[i]) * 29'(MUL_DIV255_C);
            ch_res[i] = ch_neg_reg[i] ? (ch_a_reg[i] - q_prod[i][SHIFT_C +: 6])
                                      : (ch_a_reg[i] + q_prod[i][SHIFT_C +: 6]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mix_en) begin
            for (int i = 0; i < 3; i++) begin
                ch_a_reg[i]   <= ca_ch[i];
                ch_mag_reg[i] <= m_mag[i];
                ch_neg_reg[i] <= d_neg[i];
            end
        end
    end

    // output register
    assign bar_ext = {4'd0, bar_cur_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.div_en) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_en) begin
            out_bar_reg    <= bar_ext[3:0];
            out_height_reg <= h_reg;
            out_peak_reg   <= peak_reg;
            out_color_reg  <= {ch_res[0][4:0], ch_res[1], ch_res[2][4:0]};
            out_last_reg   <= (bar_cur_reg == BW'(BARS - 1));
        end
    end

    assign m_tvalid        = out_valid_reg;
    assign out_bar_index   = out_bar_reg;
    assign out_bar_height  = out_height_reg;
    assign out_peak_height = out_peak_reg;
    assign out_bar_color   = out_color_reg;
    assign out_last_bar    = out_last_reg;

`ifndef SYNTHESIS
    a_load_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_en |-> !status.out_busy)
        else $error("result loaded while output register still held a request");

    a_clear_drops_peaks: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> (valid_reg == '0))
        else $error("peak store not cleared");

    a_peak_covers_height: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_en |=> (out_peak_reg >= out_height_reg))
        else $error("peak below bar height");

    a_height_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_height_reg <= FULL_HEIGHT))
        else $error("bar height out of range");
`endif

endmodule

@@ rtl/spectrum_bar_peak_meter_core.sv @@
// ----------------------------------------------------------------------------
// spectrum_bar_peak_meter_core
// Spectrum bar meter: bin averaging, peak hold with decay, gradient colour.
// Bins are taken one per cycle while the sequencer is idle; the last bin of a bar
// starts the per-bar sequence, one step per cycle: average, scale, height, peak,
// segment, mix and divide, during which no bin is taken. The result is loaded into
// the output register in the last step, held while an earlier result waits.
// Reset clears sums, positions, peaks (per-bar valid bits), output valid and freeze.
// ----------------------------------------------------------------------------
module spectrum_bar_peak_meter_core #(
    parameter int BARS     = 16,
    parameter int BAR_BINS = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration write port
    input  logic                         cfg_wr_en,
    input  logic [spbpm_pkg::CFG_IW-1:0] cfg_index,
    input  logic [spbpm_pkg::CFG_DW-1:0] cfg_wdata,
    // input bins
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] bin_value
    input  logic [0:0]                   s_tuser,   // [0] opcode
    // bar results
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [39:0]                  m_tdata,   // [3:0] bar_index, [11:4] bar_height,
                                                    // [19:12] peak_height, [35:20] bar_color
    output logic                         m_tlast    // last_bar
);

    import spbpm_pkg::*;

    cmd_t        cmd;
    status_t     status;
    logic [3:0]  bar_index;
    logic [7:0]  bar_height;
    logic [7:0]  peak_height;
    logic [15:0] bar_color;

    spbpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    spbpm_datapath #(
        .BARS     (BARS),
        .BAR_BINS (BAR_BINS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_opcode       (s_tuser[0]),
        .in_bin_value    (s_tdata),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .out_bar_index   (bar_index),
        .out_bar_height  (bar_height),
        .out_peak_height (peak_height),
        .out_bar_color   (bar_color),
        .out_last_bar    (m_tlast)
    );

    assign m_tdata = {4'd0, bar_color, peak_height, bar_height, bar_index};

endmodule

@@ tb/bar_meter_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bar_meter_checker
// Watches the configuration port and both streams of the spectrum bar peak
// meter. It keeps its own copy of the registers, bar sums and peaks, predicts
// every bar result from the accepted bin requests, and compares each result
// leaving the block against the oldest pending prediction. It counts failures.
// ----------------------------------------------------------------------------
module bar_meter_checker #(
    parameter int BARS     = 16,
    parameter int BAR_BINS = 8
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [spbpm_pkg::CFG_IW-1:0] cfg_index,
    input  logic [spbpm_pkg::CFG_DW-1:0] cfg_wdata,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] bin_value
    input  logic [0:0]                   s_tuser,   // [0] opcode
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [39:0]                  m_tdata,   // [3:0] bar_index, [11:4] bar_height,
                                                    // [19:12] peak_height, [35:20] bar_color
    input  logic                         m_tlast,   // last_bar
    output int unsigned                  fail_count,
    output int unsigned                  pending
);
    import spbpm_pkg::*;

    typedef struct packed {
        logic [3:0]  bar;
        logic [7:0]  height;
        logic [7:0]  peak;
        logic [15:0] color;
        logic        last;
    } bar_result_t;

    bar_result_t expected_bars[$];

    logic        freeze_q;
    logic [15:0] stops [4];
    logic [10:0] bin_total;
    int          bin_count;
    int          bar_count;
    logic [7:0]  peak_mem [BARS];

    function automatic int mix_channel(int a, int b, int t);
        return a + ((b - a) * t) / int'(FULL_SCALE);
    endfunction

    function automatic logic [15:0] blend565(logic [15:0] lo, logic [15:0] hi, int t);
        int r;
        int g;
        int b;
        r = mix_channel(lo[15:11], hi[15:11], t);
        g = mix_channel(lo[10:5], hi[10:5], t);
        b = mix_channel(lo[4:0], hi[4:0], t);
        return {r[4:0], g[5:0], b[4:0]};
    endfunction

    function automatic logic [15:0] shade_for_height(int unsigned h);
        if (h <= SEG1_TOP)
            return blend565(stops[0], stops[1], (h * FULL_SCALE) / SEG1_TOP);
        if (h <= SEG2_TOP)
            return blend565(stops[1], stops[2],
                            ((h - SEG1_TOP) * FULL_SCALE) / (SEG2_TOP - SEG1_TOP));
        return blend565(stops[2], stops[3],
                        ((h - SEG2_TOP) * FULL_SCALE) / (FULL_HEIGHT - SEG2_TOP));
    endfunction

    task automatic predict_bar(logic op, logic [7:0] bin);
        bar_result_t r;
        int unsigned avg;
        int unsigned h;
        if (op == OP_CLEAR) begin
            foreach (peak_mem[i]) peak_mem[i] = '0;
            bin_total = '0;
            bin_count = 0;
            bar_count = 0;
        end else if (!freeze_q) begin
            bin_total = bin_total + bin;
            if (bin_count + 1 < BAR_BINS) begin
                bin_count++;
            end else begin
                avg = bin_total / BAR_BINS;
                h = (avg * FULL_HEIGHT) / FULL_SCALE;
                if (h > FULL_HEIGHT) h = FULL_HEIGHT;
                if (h > peak_mem[bar_count]) peak_mem[bar_count] = h[7:0];
                r.bar    = bar_count[3:0];
                r.height = h[7:0];
                r.peak   = peak_mem[bar_count];
                r.color  = shade_for_height(h);
                r.last   = (bar_count == BARS - 1);
                expected_bars.push_back(r);
                // decay after the result is out
                if (peak_mem[bar_count] != 0) peak_mem[bar_count]--;
                bin_total = '0;
                bin_count = 0;
                bar_count = (bar_count + 1 < BARS) ? bar_count + 1 : 0;
            end
        end
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        bar_result_t want;
        if (!aresetn) begin
            freeze_q  = 1'b0;
            stops[0]  = RESET_STOP_0;
            stops[1]  = RESET_STOP_1;
            stops[2]  = RESET_STOP_2;
            stops[3]  = RESET_STOP_3;
            bin_total = '0;
            bin_count = 0;
            bar_count = 0;
            foreach (peak_mem[i]) peak_mem[i] = '0;
            expected_bars.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FREEZE: freeze_q = cfg_wdata[0];
                    REG_STOP_0: stops[0] = cfg_wdata;
                    REG_STOP_1: stops[1] = cfg_wdata;
                    REG_STOP_2: stops[2] = cfg_wdata;
                    REG_STOP_3: stops[3] = cfg_wdata;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (expected_bars.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual data %h last %b",
                             $time, m_tdata, m_tlast);
                    fail_count++;
                end else begin
                    want = expected_bars.pop_front();
                    check_field("bar_index", want.bar, m_tdata[3:0]);
                    check_field("bar_height", want.height, m_tdata[11:4]);
                    check_field("peak_height", want.peak, m_tdata[19:12]);
                    check_field("bar_color", want.color, m_tdata[35:20]);
                    check_field("tdata padding", 0, m_tdata[39:36]);
                    check_field("last_bar", want.last, m_tlast);
                end
            end
            if (s_tvalid && s_tready) predict_bar(s_tuser[0], s_tdata);
        end
        pending = expected_bars.size();
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the spectrum bar peak meter with a short directed sequence and then
// bars of random bins under several color and freeze settings and several
// patterns of source gaps and sink back-pressure. A checker module predicts
// and compares the results; this module reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import spbpm_pkg::*;

    localparam int BARS     = 16;
    localparam int BAR_BINS = 8;

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CFG_IW-1:0]   cfg_index = '0;
    logic [CFG_DW-1:0]   cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = '0;
    logic [0:0]          s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b1;
    logic [39:0]         m_tdata;
    logic                m_tlast;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    spectrum_bar_peak_meter_core #(
        .BARS     (BARS),
        .BAR_BINS (BAR_BINS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    bar_meter_checker #(
        .BARS     (BARS),
        .BAR_BINS (BAR_BINS)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // valid stays high on return so back-to-back requests need no extra edge
    task automatic send_request(logic op, logic [7:0] bin);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= bin;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_settings(logic frz, logic [15:0] c0, logic [15:0] c1,
                                  logic [15:0] c2, logic [15:0] c3);
        logic [CFG_IW-1:0] idx [5];
        logic [15:0]       val [5];
        idx = '{REG_FREEZE, REG_STOP_0, REG_STOP_1, REG_STOP_2, REG_STOP_3};
        val = '{{15'd0, frz}, c0, c1, c2, c3};
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // hold the source until every result is out, then let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic send_random_bar();
        int         kind;
        logic [7:0] level;
        kind  = $urandom_range(9);
        level = 8'($urandom_range(255));
        case (kind)
            0: level = 8'd0;
            1: level = 8'd255;
            2: level = 8'd85;    // lands exactly on the first segment boundary
            3: level = 8'd170;   // lands exactly on the second segment boundary
            default: ;
        endcase
        for (int i = 0; i < BAR_BINS; i++) begin
            if (kind >= 6)
                send_request(OP_BIN, 8'($urandom_range(255)));
            else if (kind == 5)
                send_request(OP_BIN, level ^ 8'($urandom_range(7)));
            else
                send_request(OP_BIN, level);
        end
    endtask

    task automatic run_bars(int n);
        int roll;
        for (int b = 0; b < n; b++) begin
            roll = $urandom_range(99);
            if (roll < 4) begin
                send_request(OP_CLEAR, 8'($urandom_range(255)));
            end else if (roll < 8) begin
                // abandon a bar partway through
                repeat ($urandom_range(1, BAR_BINS - 1))
                    send_request(OP_BIN, 8'($urandom_range(255)));
                send_request(OP_CLEAR, 8'($urandom_range(255)));
            end
            send_random_bar();
        end
    endtask

    initial begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // full-scale bar, then a partial bar dropped by a clear, then a bar at 66
        repeat (BAR_BINS) send_request(OP_BIN, 8'hFF);
        send_request(OP_BIN, 8'h01);
        send_request(OP_BIN, 8'h80);
        send_request(OP_BIN, 8'h7F);
        send_request(OP_CLEAR, 8'h00);
        repeat (BAR_BINS) send_request(OP_BIN, 8'd85);
        settle();

        // freeze drops bins; a clear still acts
        write_settings(1'b1, RESET_STOP_0, RESET_STOP_1, RESET_STOP_2, RESET_STOP_3);
        send_request(OP_BIN, 8'hAA);
        send_request(OP_BIN, 8'h55);
        send_request(OP_CLEAR, 8'hFF);
        settle();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                    write_settings(1'b0, RESET_STOP_0, RESET_STOP_1,
                                   RESET_STOP_2, RESET_STOP_3);
                end
                1: begin
                    send_idle_pct = 65; recv_stall_pct = 0;
                    write_settings(1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 65;
                    write_settings(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                end
                3: begin
                    send_idle_pct = 20; recv_stall_pct = 20;
                    write_settings(1'b0, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
                end
                default: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                    write_settings(1'b0, 16'($urandom_range(65535)),
                                   16'($urandom_range(65535)),
                                   16'($urandom_range(65535)),
                                   16'($urandom_range(65535)));
                end
            endcase
            run_bars(10);
            settle();

            if (ph == 2) begin
                // a frozen stretch with random bins and the odd clear
                write_settings(1'b1, 16'($urandom_range(65535)),
                               16'($urandom_range(65535)),
                               16'($urandom_range(65535)),
                               16'($urandom_range(65535)));
                repeat (16) begin
                    if ($urandom_range(9) == 0)
                        send_request(OP_CLEAR, 8'($urandom_range(255)));
                    else
                        send_request(OP_BIN, 8'($urandom_range(255)));
                end
                settle();
            end
        end

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/spbpm_pkg.sv
rtl/spbpm_ram.sv
rtl/spbpm_ctrl.sv
rtl/spbpm_datapath.sv
rtl/spectrum_bar_peak_meter_core.sv
tb/bar_meter_checker.sv
tb/testbench.sv
